[rtl/chained_block_free_list_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Chained block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define CHAINED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define CBFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent
`define CBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cbfl_pkg.sv]
// ----------------------------------------------------------------------------
// Chained block allocator package
// Widths, register codes, sequencer states and link table helpers.
// ----------------------------------------------------------------------------
package cbfl_pkg;

  // Pool and field sizes
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LINK_W     = CNT_W;
  localparam int ADDR_W     = 32;
  localparam int BB_W       = 17;
  localparam int AL_W       = 13;
  localparam int PROD_W     = IDX_W + BB_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};
  localparam logic [CNT_W-1:0]  POOL_MAX = CNT_W'(MAX_BLOCKS);

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_POOL_BLOCKS = CNT_W'(1024);
  localparam logic [BB_W-1:0]   RST_BLOCK_BYTES = BB_W'(64);
  localparam logic [AL_W-1:0]   RST_ALIGN_BYTES = AL_W'(16);
  localparam logic [ADDR_W-1:0] RST_POOL_BASE   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BLOCKS = 2'd0,
    CFG_BLOCK_BYTES = 2'd1,
    CFG_ALIGN_BYTES = 2'd2,
    CFG_POOL_BASE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  // Link table port request
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } link_req_t;

  // Link of an entry that has not been rewritten since the list was rebuilt
  function automatic logic [LINK_W-1:0] init_link(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] succ;
    succ = {1'b0, idx} + CNT_W'(1);
    return (succ < n) ? LINK_W'(succ) : LINK_END;
  endfunction

endpackage

[rtl/cbfl_ifs.sv]
// ----------------------------------------------------------------------------
// Chained block allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbfl_in_if import cbfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] block_count;

  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

interface cbfl_out_if import cbfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [IDX_W-1:0]  first_index;
  logic [ADDR_W-1:0] block_address;
  logic [CNT_W-1:0]  free_left;

  modport source (output valid, output granted, output first_index,
                  output block_address, output free_left, input ready);
  modport sink   (input valid, input granted, input first_index,
                  input block_address, input free_left, output ready);
endinterface

[rtl/cbfl_link_ram.sv]
// ----------------------------------------------------------------------------
// Link table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbfl_link_ram import cbfl_pkg::*; (
  input  logic              clk,
  input  link_req_t         req,
  output logic [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [MAX_BLOCKS];

  // Write one link
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read one link
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

[rtl/chained_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Chained block free list allocator
// Pops a run of blocks from the free list head, one link per cycle through the
// link table, then forms the block address with one multiply and one add.
// ----------------------------------------------------------------------------
// Sequence: a refused item passes ST_CHECK and ST_DONE; a granted run of N blocks
//   (a count of zero counts as one) passes ST_CHECK, ST_WALK for each block popped,
//   ST_MUL, ST_SUM and ST_DONE, which holds while the output register is stalled.
// Overlap: no new item is taken until the last result is in the output register.
// Reset: synchronous, active low; control and configuration registers return to their
//   defaults and the free list is rebuilt at once by a fill count, with no clearing pass.
module chained_block_free_list_allocator import cbfl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cbfl_in_if.sink               in_ch,
  cbfl_out_if.source            out_ch
);

  // Configuration registers
  logic [CNT_W-1:0]  pool_blocks_r;
  logic [BB_W-1:0]   block_bytes_r;
  logic [AL_W-1:0]   align_bytes_r;
  logic [ADDR_W-1:0] pool_base_r;

  // Control state
  state_t            state_r, state_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working payload
  logic [CNT_W-1:0]  want_r, want_nxt;
  logic              granted_r, granted_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // Output payload
  logic              out_granted_r, out_granted_nxt;
  logic [IDX_W-1:0]  out_first_r, out_first_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]  out_free_r, out_free_nxt;

  logic              in_ready_c;
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rd;
  logic [LINK_W-1:0] link_val;
  logic [CNT_W-1:0]  pool_n;
  logic [CNT_W-1:0]  free_cnt;
  logic [AL_W-1:0]   align_m1;
  logic [ADDR_W:0]   base_sum;
  logic [ADDR_W-1:0] aligned_base;

  cbfl_link_ram u_link_ram (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rd)
  );

  // Saturate pool size and count free blocks
  assign pool_n   = (pool_blocks_r > POOL_MAX) ? POOL_MAX : pool_blocks_r;
  assign free_cnt = (used_r < pool_n) ? (pool_n - used_r) : '0;

  // Round the raw base up to a power-of-two alignment; zero alignment acts as one
  assign align_m1     = (align_bytes_r == '0) ? '0 : (align_bytes_r - AL_W'(1));
  assign base_sum     = {1'b0, pool_base_r} + (ADDR_W + 1)'(align_m1);
  assign aligned_base = base_sum[ADDR_W-1:0] & ~ADDR_W'(align_m1);

  // Entries at or past the fill count still hold their rebuilt link
  assign link_val = ({1'b0, cur_r} >= used_r) ? init_link(cur_r, pool_n) : link_rd;

  // Sequencer: next state, link table access and output load
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    used_nxt        = used_r;
    remain_nxt      = remain_r;
    want_nxt        = want_r;
    granted_nxt     = granted_r;
    first_nxt       = first_r;
    cur_nxt         = cur_r;
    prod_nxt        = prod_r;
    base_nxt        = base_r;
    addr_nxt        = addr_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_granted_nxt = out_granted_r;
    out_first_nxt   = out_first_r;
    out_addr_nxt    = out_addr_r;
    out_free_nxt    = out_free_r;
    in_ready_c      = 1'b0;
    link_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready_c = 1'b1;
        if (in_ch.valid) begin
          want_nxt  = (in_ch.block_count == '0) ? CNT_W'(1) : in_ch.block_count;
          state_nxt = ST_CHECK;
        end
      end

      // Refuse or start the walk at the head
      ST_CHECK: begin
        if ((want_r > free_cnt) || (free_cnt == '0) || (head_r >= LINK_W'(MAX_BLOCKS))) begin
          granted_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          granted_nxt    = 1'b1;
          first_nxt      = head_r[IDX_W-1:0];
          cur_nxt        = head_r[IDX_W-1:0];
          remain_nxt     = want_r;
          link_req.re    = 1'b1;
          link_req.raddr = head_r[IDX_W-1:0];
          state_nxt      = ST_WALK;
        end
      end

      // Pop one block a cycle and link it to the next
      ST_WALK: begin
        head_nxt       = link_val;
        used_nxt       = used_r + CNT_W'(1);
        remain_nxt     = remain_r - CNT_W'(1);
        link_req.we    = 1'b1;
        link_req.waddr = cur_r;
        if ((remain_r == CNT_W'(1)) || (link_val >= LINK_W'(MAX_BLOCKS))) begin
          link_req.wdata = LINK_END;
          state_nxt      = ST_MUL;
        end else begin
          link_req.wdata = link_val;
          link_req.re    = 1'b1;
          link_req.raddr = link_val[IDX_W-1:0];
          cur_nxt        = link_val[IDX_W-1:0];
        end
      end

      ST_MUL: begin
        prod_nxt  = PROD_W'(first_r) * PROD_W'(block_bytes_r);
        base_nxt  = aligned_base;
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        addr_nxt  = base_r + ADDR_W'(prod_r);
        state_nxt = ST_DONE;
      end

      // Hold the result until the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = granted_r;
          out_first_nxt   = granted_r ? first_r : '0;
          out_addr_nxt    = granted_r ? addr_r : '0;
          out_free_nxt    = free_cnt;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A pool size write rebuilds the free list
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_POOL_BLOCKS)) begin
      head_nxt = '0;
      used_nxt = '0;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      used_r        <= '0;
      remain_r      <= '0;
      out_valid_r   <= 1'b0;
      pool_blocks_r <= RST_POOL_BLOCKS;
      block_bytes_r <= RST_BLOCK_BYTES;
      align_bytes_r <= RST_ALIGN_BYTES;
      pool_base_r   <= RST_POOL_BASE;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_POOL_BLOCKS: begin
            pool_blocks_r <= cfg_data[CNT_W-1:0];
          end
          CFG_BLOCK_BYTES: begin
            block_bytes_r <= cfg_data[BB_W-1:0];
          end
          CFG_ALIGN_BYTES: begin
            align_bytes_r <= cfg_data[AL_W-1:0];
          end
          CFG_POOL_BASE: begin
            pool_base_r <= cfg_data[ADDR_W-1:0];
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    want_r        <= want_nxt;
    granted_r     <= granted_nxt;
    first_r       <= first_nxt;
    cur_r         <= cur_nxt;
    prod_r        <= prod_nxt;
    base_r        <= base_nxt;
    addr_r        <= addr_nxt;
    out_granted_r <= out_granted_nxt;
    out_first_r   <= out_first_nxt;
    out_addr_r    <= out_addr_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign in_ch.ready          = in_ready_c;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted       = out_granted_r;
  assign out_ch.first_index   = out_first_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.free_left     = out_free_r;

endmodule

[rtl/cbfl_checker.sv]
// ----------------------------------------------------------------------------
// Chained block allocator checker
// Port-level assertions on handshake and result consistency.
// ----------------------------------------------------------------------------
`include "chained_block_free_list_allocator_macros.svh"

module cbfl_checker import cbfl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_granted,
  input logic [IDX_W-1:0]  out_first_index,
  input logic [ADDR_W-1:0] out_block_address,
  input logic [CNT_W-1:0]  out_free_left
);

  // A stalled result stays offered
  `CBFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A refused item reports no block
  `CBFL_ASSERT_SAME(a_refused_zero, out_valid && !out_granted, (out_first_index == '0) && (out_block_address == '0), "refused item carries a block")

  // A grant takes at least one block, so the pool is never wholly free after it
  `CBFL_ASSERT_SAME(a_grant_free, out_valid && out_granted, out_free_left < POOL_MAX, "grant left the whole pool free")

  // The block is busy right after it takes an item
  `CBFL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accepted item")

endmodule

bind chained_block_free_list_allocator cbfl_checker u_cbfl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_granted       (out_ch.granted),
  .out_first_index   (out_ch.first_index),
  .out_block_address (out_ch.block_address),
  .out_free_left     (out_ch.free_left)
);
